>>> rtl/core/gmw_pkg.sv
// shared types and codes for the grid maze depth-first walker
`timescale 1ns / 1ps
`default_nettype none

package gmw_pkg;

   localparam int POS_W    = 6;
   localparam int KIND_W   = 2;
   localparam int DIR_W    = 2;
   localparam int STATUS_W = 3;
   localparam int GRID_W   = 7;

   // cell codes; a visited cell is stored as a wall
   localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

   // directions in probe order; the opposite direction is the bitwise inverse
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STS_FORWARD  = 3'd0,
      STS_BACK     = 3'd1,
      STS_GOAL     = 3'd2,
      STS_NOPATH   = 3'd3,
      STS_NOTREADY = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_PROBE  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // neighbour of the current cell, one bit wider to see the edge
   typedef struct packed {
      logic [GRID_W-1:0] row;
      logic [GRID_W-1:0] col;
      logic              in_grid;
   } nbr_type;

endpackage

`default_nettype wire

>>> rtl/core/gmw_if.sv
// request and response channel interfaces of the maze walker
`timescale 1ns / 1ps
`default_nettype none

interface gmw_req_if import gmw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [POS_W-1:0]  cell_row;
   logic [POS_W-1:0]  cell_col;
   logic [KIND_W-1:0] cell_kind;

   modport source (output valid, func, cell_row, cell_col, cell_kind, input ready);
   modport sink   (input valid, func, cell_row, cell_col, cell_kind, output ready);
endinterface

interface gmw_rsp_if import gmw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DIR_W-1:0]    move_dir;
   logic [POS_W-1:0]    pos_row;
   logic [POS_W-1:0]    pos_col;

   modport source (output valid, status, move_dir, pos_row, pos_col, input ready);
   modport sink   (input valid, status, move_dir, pos_row, pos_col, output ready);
endinterface

`default_nettype wire

>>> rtl/core/grid_maze_dfs_walker.sv
// grid maze depth-first walker: cell store, direction stack and step sequencer
// a load beat is taken in idle and gives no result
// a step beat goes from the accept in idle through the probe state, once per neighbour tried
// (none at the goal or before start and end are loaded), then finish writes the output reg
// one beat in flight at a time; the finish cycle holds while a result waits for rsp ready
// reset clears position, goal, flags and stack count, grid to 64 x 64; memories not cleared
`timescale 1ns / 1ps
`default_nettype none

module grid_maze_dfs_walker import gmw_pkg::*; #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int STACK_DEPTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   gmw_req_if.sink          req_chan,
   gmw_rsp_if.source        rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   // only 6-bit positions reach the store
   localparam int ER         = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int EC         = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int RW         = $clog2(ER);
   localparam int CW         = $clog2(EC);
   localparam int AW         = RW + CW;
   localparam int CELL_DEPTH = 1 << AW;
   localparam int SW         = $clog2(STACK_DEPTH);
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1);

   localparam logic [GRID_W-1:0] LIM_ROWS  = GRID_W'(ER);
   localparam logic [GRID_W-1:0] LIM_COLS  = GRID_W'(EC);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

   state_type           state_ff, state_in;
   logic [DIR_W-1:0]    dir_ff, dir_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]    cur_row_ff, cur_row_in, cur_col_ff, cur_col_in;
   logic [POS_W-1:0]    goal_row_ff, goal_row_in, goal_col_ff, goal_col_in;
   logic                start_seen_ff, start_seen_in, goal_seen_ff, goal_seen_in;
   logic [GRID_W-1:0]   grid_rows_ff, grid_rows_in, grid_cols_ff, grid_cols_in;
   status_type          res_status_ff, res_status_in;
   logic [DIR_W-1:0]    res_dir_ff, res_dir_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DIR_W-1:0]    rsp_dir_ff, rsp_dir_in;
   logic [POS_W-1:0]    rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;

   logic [KIND_W-1:0]   cell_mem [CELL_DEPTH];
   logic [KIND_W-1:0]   cell_rdata_ff;
   logic                cell_we;
   logic [AW-1:0]       cell_waddr, cell_raddr;
   logic [KIND_W-1:0]   cell_wdata;

   logic [DIR_W-1:0]    stack_mem [STACK_DEPTH];
   logic [DIR_W-1:0]    stack_rdata_ff;
   logic                stack_we, stack_re;
   logic [SW-1:0]       stack_waddr, stack_raddr;
   logic [CNT_W-1:0]    cnt_m1;

   logic [GRID_W-1:0]   lim_rows, lim_cols;
   nbr_type             nb_first, nb_eval, nb_next, nb_back;
   logic                req_take, cfg_write, load_in_store, probe_open, fwd_take, back_take;
   logic [DIR_W-1:0]    back_dir;
   logic                out_free;

   function automatic nbr_type nbr_of(input logic [DIR_W-1:0]  d,
                                      input logic [POS_W-1:0]  r,
                                      input logic [POS_W-1:0]  c,
                                      input logic [GRID_W-1:0] lr,
                                      input logic [GRID_W-1:0] lc);
      nbr_type          n;
      logic             wrap;
      n.row = {1'b0, r};
      n.col = {1'b0, c};
      wrap  = 1'b0;
      unique case (d)
         DIR_DOWN:  n.row = {1'b0, r} + GRID_W'(1);
         DIR_LEFT:  begin
            wrap  = (c == '0);
            n.col = {1'b0, c} - GRID_W'(1);
         end
         DIR_RIGHT: n.col = {1'b0, c} + GRID_W'(1);
         DIR_UP:    begin
            wrap  = (r == '0);
            n.row = {1'b0, r} - GRID_W'(1);
         end
         default:   wrap = 1'b1;
      endcase
      n.in_grid = !wrap && (n.row < lr) && (n.col < lc);
      return n;
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [GRID_W-1:0] r,
                                             input logic [GRID_W-1:0] c);
      return {r[RW-1:0], c[CW-1:0]};
   endfunction

   // register values clamped to 1 .. store size
   always_comb begin
      lim_rows = grid_rows_ff;
      if (grid_rows_ff == '0) lim_rows = GRID_W'(1);
      else if (grid_rows_ff > LIM_ROWS) lim_rows = LIM_ROWS;
      lim_cols = grid_cols_ff;
      if (grid_cols_ff == '0) lim_cols = GRID_W'(1);
      else if (grid_cols_ff > LIM_COLS) lim_cols = LIM_COLS;
   end

   assign nb_first = nbr_of(DIR_DOWN, cur_row_ff, cur_col_ff, lim_rows, lim_cols);
   assign nb_eval  = nbr_of(dir_ff, cur_row_ff, cur_col_ff, lim_rows, lim_cols);
   assign nb_next  = nbr_of(dir_ff + DIR_W'(1), cur_row_ff, cur_col_ff, lim_rows, lim_cols);
   assign back_dir = ~stack_rdata_ff;
   assign nb_back  = nbr_of(back_dir, cur_row_ff, cur_col_ff, lim_rows, lim_cols);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign load_in_store  = ({1'b0, req_chan.cell_row} < LIM_ROWS) &&
                           ({1'b0, req_chan.cell_col} < LIM_COLS);

   assign probe_open = nb_eval.in_grid && (cell_rdata_ff != KIND_WALL) && (cnt_ff < CNT_FULL);
   assign fwd_take   = (state_ff == ST_PROBE) && probe_open;
   assign back_take  = (state_ff == ST_PROBE) && !probe_open && (dir_ff == DIR_UP) &&
                       (cnt_ff != '0);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign cnt_m1      = cnt_ff - CNT_ONE;
   assign stack_raddr = cnt_m1[SW-1:0];
   assign stack_waddr = cnt_ff[SW-1:0];
   assign stack_we    = fwd_take;
   assign stack_re    = req_take && (req_chan.func == FUNC_STEP);

   // load writes in the accept cycle; the visited mark is written when the move is made
   always_comb begin
      cell_raddr = (state_ff == ST_IDLE) ? addr_of(nb_first.row, nb_first.col)
                                         : addr_of(nb_next.row, nb_next.col);
      cell_we    = 1'b0;
      cell_waddr = addr_of({1'b0, cur_row_ff}, {1'b0, cur_col_ff});
      cell_wdata = KIND_WALL;
      if (req_take && (req_chan.func == FUNC_LOAD)) begin
         cell_we    = load_in_store;
         cell_waddr = addr_of({1'b0, req_chan.cell_row}, {1'b0, req_chan.cell_col});
         cell_wdata = req_chan.cell_kind;
      end else if (fwd_take || back_take) begin
         cell_we = ({1'b0, cur_row_ff} < LIM_ROWS) && ({1'b0, cur_col_ff} < LIM_COLS);
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      cell_rdata_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_waddr] <= dir_ff;
      if (stack_re) stack_rdata_ff <= stack_mem[stack_raddr];
   end

   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = paddr[2] ? {25'd0, grid_cols_ff} : {25'd0, grid_rows_ff};

   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      cnt_in        = cnt_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      goal_row_in   = goal_row_ff;
      goal_col_in   = goal_col_ff;
      start_seen_in = start_seen_ff;
      goal_seen_in  = goal_seen_ff;
      grid_rows_in  = grid_rows_ff;
      grid_cols_in  = grid_cols_ff;
      res_status_in = res_status_ff;
      res_dir_in    = res_dir_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;

      if (cfg_write) begin
         if (paddr[2]) grid_cols_in = pwdata[GRID_W-1:0];
         else          grid_rows_in = pwdata[GRID_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.func == FUNC_LOAD) begin
                  if (load_in_store && (req_chan.cell_kind == KIND_START)) begin
                     cur_row_in    = req_chan.cell_row;
                     cur_col_in    = req_chan.cell_col;
                     cnt_in        = '0;
                     start_seen_in = 1'b1;
                  end else if (load_in_store && (req_chan.cell_kind == KIND_END)) begin
                     goal_row_in  = req_chan.cell_row;
                     goal_col_in  = req_chan.cell_col;
                     goal_seen_in = 1'b1;
                  end
               end else begin
                  res_dir_in = DIR_DOWN;
                  dir_in     = DIR_DOWN;
                  if (!start_seen_ff || !goal_seen_ff) begin
                     res_status_in = STS_NOTREADY;
                     state_in      = ST_FINISH;
                  end else if ((cur_row_ff == goal_row_ff) && (cur_col_ff == goal_col_ff)) begin
                     res_status_in = STS_GOAL;
                     state_in      = ST_FINISH;
                  end else begin
                     state_in = ST_PROBE;
                  end
               end
            end
         end
         ST_PROBE: begin
            if (probe_open) begin
               cnt_in        = cnt_ff + CNT_ONE;
               cur_row_in    = nb_eval.row[POS_W-1:0];
               cur_col_in    = nb_eval.col[POS_W-1:0];
               res_status_in = STS_FORWARD;
               res_dir_in    = dir_ff;
               state_in      = ST_FINISH;
            end else if (dir_ff == DIR_UP) begin
               if (cnt_ff == '0) begin
                  res_status_in = STS_NOPATH;
                  res_dir_in    = DIR_DOWN;
               end else begin
                  // dead end: step back against the last pushed direction
                  cnt_in        = cnt_m1;
                  cur_row_in    = nb_back.row[POS_W-1:0];
                  cur_col_in    = nb_back.col[POS_W-1:0];
                  res_status_in = STS_BACK;
                  res_dir_in    = back_dir;
               end
               state_in = ST_FINISH;
            end else begin
               dir_in = dir_ff + DIR_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_dir_in    = res_dir_ff;
               rsp_row_in    = cur_row_ff;
               rsp_col_in    = cur_col_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         goal_row_ff   <= '0;
         goal_col_ff   <= '0;
         start_seen_ff <= 1'b0;
         goal_seen_ff  <= 1'b0;
         grid_rows_ff  <= GRID_W'(64);
         grid_cols_ff  <= GRID_W'(64);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         goal_row_ff   <= goal_row_in;
         goal_col_ff   <= goal_col_in;
         start_seen_ff <= start_seen_in;
         goal_seen_ff  <= goal_seen_in;
         grid_rows_ff  <= grid_rows_in;
         grid_cols_ff  <= grid_cols_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff        <= dir_in;
      res_status_ff <= res_status_in;
      res_dir_ff    <= res_dir_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.move_dir = rsp_dir_ff;
   assign rsp_chan.pos_row  = rsp_row_ff;
   assign rsp_chan.pos_col  = rsp_col_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("stack count beyond depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result beat raised outside finish");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      fwd_take |=> (cnt_ff == $past(cnt_ff) + CNT_ONE))
      else $error("forward move did not push");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      back_take |=> (cnt_ff == $past(cnt_ff) - CNT_ONE) && (state_ff == ST_FINISH))
      else $error("backtrack did not pop");

endmodule

`default_nettype wire

>>> bench/grid_maze_dfs_walker_tb.sv
// self-checking testbench for the grid maze depth-first walker
`timescale 1ns / 1ps

module grid_maze_dfs_walker_tb;
   import gmw_pkg::*;

   localparam int GRID_MAX    = 64;
   localparam int STACK_SIZE  = 4096;
   localparam int CSR_ROWS    = 0;
   localparam int CSR_COLS    = 1;
   localparam int ITEM_TARGET = 1750;
   localparam int SQUEEZE_CYC = 400;

   typedef struct packed {
      logic              func;
      logic [POS_W-1:0]  cell_row;
      logic [POS_W-1:0]  cell_col;
      logic [KIND_W-1:0] cell_kind;
   } maze_item_type;

   typedef struct {
      status_type       status;
      logic [DIR_W-1:0] move_dir;
      logic [POS_W-1:0] pos_row;
      logic [POS_W-1:0] pos_col;
   } step_outcome_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   gmw_req_if req_bus ();
   gmw_rsp_if rsp_bus ();

   grid_maze_dfs_walker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // walker state as the bench sees it
   logic [KIND_W-1:0] maze_cells [0:GRID_MAX-1][0:GRID_MAX-1];
   logic [DIR_W-1:0]  dir_stack [0:STACK_SIZE-1];
   int                stack_fill;
   logic [POS_W-1:0]  cur_row, cur_col, goal_row, goal_col;
   bit                start_seen, goal_seen;
   logic [GRID_W-1:0] rows_reg, cols_reg;

   maze_item_type    pending_items [$];
   step_outcome_type expected_steps [$];
   maze_item_type    offer;

   int  error_count, items_issued, loads_taken, steps_checked, csr_writes, mazes_run;
   int  status_seen [0:4];
   int  sender_gap, rsp_hold, squeeze_req, squeeze_seen;
   bit  sender_jitter, receiver_jitter;

   function automatic int grid_limit(input logic [GRID_W-1:0] v);
      int lim;
      lim = v;
      if (lim < 1) lim = 1;
      if (lim > GRID_MAX) lim = GRID_MAX;
      return lim;
   endfunction

   function automatic void neighbour_of(input logic [DIR_W-1:0] d, output int nr, output int nc);
      nr = int'(cur_row);
      nc = int'(cur_col);
      case (d)
         DIR_DOWN:  nr = int'(cur_row) + 1;
         DIR_LEFT:  nc = int'(cur_col) - 1;
         DIR_RIGHT: nc = int'(cur_col) + 1;
         default:   nr = int'(cur_row) - 1;
      endcase
   endfunction

   function automatic bit cell_passable(input int nr, input int nc);
      if (nr < 0 || nc < 0 || nr >= grid_limit(rows_reg) || nc >= grid_limit(cols_reg))
         return 1'b0;
      return maze_cells[nr][nc] != KIND_WALL;
   endfunction

   // leaving a cell marks it visited
   function automatic void step_to(input logic [DIR_W-1:0] d);
      int nr, nc;
      neighbour_of(d, nr, nc);
      maze_cells[cur_row][cur_col] = KIND_WALL;
      cur_row = nr[POS_W-1:0];
      cur_col = nc[POS_W-1:0];
   endfunction

   function automatic void walk_accept(input maze_item_type it);
      int               nr, nc, i;
      bit               found;
      logic [DIR_W-1:0] way;
      step_outcome_type o;
      if (it.func == FUNC_LOAD) begin
         maze_cells[it.cell_row][it.cell_col] = it.cell_kind;
         if (it.cell_kind == KIND_START) begin
            cur_row    = it.cell_row;
            cur_col    = it.cell_col;
            stack_fill = 0;
            start_seen = 1'b1;
         end else if (it.cell_kind == KIND_END) begin
            goal_row  = it.cell_row;
            goal_col  = it.cell_col;
            goal_seen = 1'b1;
         end
         loads_taken++;
         return;
      end
      o.move_dir = DIR_DOWN;
      if (!start_seen || !goal_seen) begin
         o.status = STS_NOTREADY;
      end else if (cur_row == goal_row && cur_col == goal_col) begin
         o.status = STS_GOAL;
      end else begin
         found = 1'b0;
         way   = DIR_DOWN;
         if (stack_fill < STACK_SIZE) begin
            for (i = 0; i < 4 && !found; i++) begin
               neighbour_of(DIR_W'(i), nr, nc);
               if (cell_passable(nr, nc)) begin
                  found = 1'b1;
                  way   = DIR_W'(i);
               end
            end
         end
         if (found) begin
            dir_stack[stack_fill] = way;
            stack_fill++;
            step_to(way);
            o.status   = STS_FORWARD;
            o.move_dir = way;
         end else if (stack_fill == 0) begin
            o.status = STS_NOPATH;
         end else begin
            stack_fill--;
            way = DIR_UP - dir_stack[stack_fill];
            step_to(way);
            o.status   = STS_BACK;
            o.move_dir = way;
         end
      end
      o.pos_row = cur_row;
      o.pos_col = cur_col;
      expected_steps.insert(expected_steps.size(), o);
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         sender_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            walk_accept(offer);
         if (!req_bus.valid || req_bus.ready) begin
            if (sender_gap > 0) begin
               sender_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               offer = pending_items.pop_front();
               req_bus.func      <= offer.func;
               req_bus.cell_row  <= offer.cell_row;
               req_bus.cell_col  <= offer.cell_col;
               req_bus.cell_kind <= offer.cell_kind;
               req_bus.valid     <= 1'b1;
               if (sender_jitter) sender_gap = pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      step_outcome_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            steps_checked++;
            if (expected_steps.size() == 0) begin
               flag_mismatch("unexpected result beat", rsp_bus.status, -1);
            end else begin
               want = expected_steps.pop_front();
               status_seen[want.status]++;
               if (rsp_bus.status !== want.status)
                  flag_mismatch("status", rsp_bus.status, want.status);
               if (rsp_bus.move_dir !== want.move_dir)
                  flag_mismatch("move_dir", rsp_bus.move_dir, want.move_dir);
               if (rsp_bus.pos_row !== want.pos_row)
                  flag_mismatch("pos_row", rsp_bus.pos_row, want.pos_row);
               if (rsp_bus.pos_col !== want.pos_col)
                  flag_mismatch("pos_col", rsp_bus.pos_col, want.pos_col);
            end
         end
         if (squeeze_req != squeeze_seen) begin
            squeeze_seen++;
            rsp_hold = SQUEEZE_CYC;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (receiver_jitter && $urandom_range(0, 99) < 30) begin
            rsp_hold = pick_gap();
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic push_item(input logic func, input int row, input int col,
                            input logic [KIND_W-1:0] kind);
      maze_item_type it;
      it.func      = func;
      it.cell_row  = row[POS_W-1:0];
      it.cell_col  = col[POS_W-1:0];
      it.cell_kind = kind;
      pending_items.insert(pending_items.size(), it);
      items_issued++;
   endtask

   // step beats carry junk in the cell fields
   task automatic push_step();
      push_item(FUNC_STEP, $urandom_range(0, 63), $urandom_range(0, 63), KIND_W'($urandom));
   endtask

   task automatic csr_write(input int idx, input logic [GRID_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(idx * 4);
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_ROWS) rows_reg = value;
      else cols_reg = value;
      csr_writes++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input int idx);
      logic [GRID_W-1:0] want;
      want = (idx == CSR_ROWS) ? rows_reg : cols_reg;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= 3'(idx * 4);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[GRID_W-1:0] !== want)
         flag_mismatch(idx == CSR_ROWS ? "grid_rows readback" : "grid_cols readback",
                       prdata[GRID_W-1:0], want);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // wait for every beat to go in and every result to come back, then let the block settle
   task automatic settle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_steps.size() != 0);
      repeat (10) @(negedge clock);
   endtask

   function automatic logic [GRID_W-1:0] pick_grid_reg();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return GRID_W'($urandom_range(2, 6));
      if (r < 78) return GRID_W'(1);
      if (r < 84) return GRID_W'(0);
      if (r < 90) return GRID_W'(64);
      if (r < 95) return GRID_W'($urandom_range(65, 127));
      return GRID_W'($urandom_range(7, 12));
   endfunction

   task automatic configure(input int slot);
      logic [GRID_W-1:0] rv, cv;
      case (slot)
         0: begin rv = 127; cv = 2;  end
         1: begin rv = 2;   cv = 0;  end
         2: begin rv = 64;  cv = 1;  end
         3: begin rv = 1;   cv = 64; end
         4: begin rv = 0;   cv = 0;  end
         5: begin rv = 65;  cv = 2;  end
         default: begin
            rv = pick_grid_reg();
            cv = pick_grid_reg();
            // keep the load count of one maze modest
            if (grid_limit(rv) * grid_limit(cv) > 130) cv = GRID_W'($urandom_range(1, 2));
         end
      endcase
      settle();
      csr_write(CSR_ROWS, rv);
      csr_write(CSR_COLS, cv);
      csr_check(CSR_ROWS);
      csr_check(CSR_COLS);
      @(negedge clock);
   endtask

   // load each cell in use, then start and mostly end, then a run of steps with stray loads
   task automatic load_maze(input bit squeeze);
      int rows_eff, cols_eff, r, c, sr, sc, er, ec, style, wall_pct, n, i;
      bit with_end, end_first;
      rows_eff = grid_limit(rows_reg);
      cols_eff = grid_limit(cols_reg);
      wall_pct = $urandom_range(5, 45);
      for (r = 0; r < rows_eff; r++)
         for (c = 0; c < cols_eff; c++)
            push_item(FUNC_LOAD, r, c,
                      ($urandom_range(0, 99) < wall_pct) ? KIND_WALL : KIND_OPEN);
      sr = $urandom_range(0, rows_eff - 1);
      sc = $urandom_range(0, cols_eff - 1);
      er = $urandom_range(0, rows_eff - 1);
      ec = $urandom_range(0, cols_eff - 1);
      with_end = 1'b1;
      style = $urandom_range(0, 99);
      if (style < 8) begin
         er = sr;
         ec = sc;
      end else if (style < 16) begin
         with_end = 1'b0;
      end else if (style < 22) begin
         sr = $urandom_range(0, 63);
         sc = $urandom_range(0, 63);
      end
      end_first = $urandom_range(0, 1);
      if (with_end && end_first) push_item(FUNC_LOAD, er, ec, KIND_END);
      push_item(FUNC_LOAD, sr, sc, KIND_START);
      if (with_end && !end_first) push_item(FUNC_LOAD, er, ec, KIND_END);
      if (squeeze) begin
         // hold the result side while a long run of steps piles up behind it
         do @(negedge clock); while (pending_items.size() != 0);
         squeeze_req++;
      end
      n = 2 * rows_eff * cols_eff + $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 5)
            push_item(FUNC_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                      KIND_W'($urandom));
         push_step();
      end
      mazes_run++;
   endtask

   initial begin
      int ep, r, c;
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_LOAD;
      req_bus.cell_row  = '0;
      req_bus.cell_col  = '0;
      req_bus.cell_kind = KIND_OPEN;
      rsp_bus.ready     = 1'b0;
      for (r = 0; r < GRID_MAX; r++)
         for (c = 0; c < GRID_MAX; c++)
            maze_cells[r][c] = KIND_OPEN;
      for (r = 0; r < STACK_SIZE; r++) dir_stack[r] = DIR_DOWN;
      stack_fill = 0;
      cur_row = '0;
      cur_col = '0;
      goal_row = '0;
      goal_col = '0;
      start_seen = 1'b0;
      goal_seen  = 1'b0;
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      sender_jitter   = 1'b0;
      receiver_jitter = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: one-row corridor of three cells, rows register at zero
      csr_write(CSR_ROWS, 0);
      csr_write(CSR_COLS, 3);
      @(negedge clock);
      push_item(FUNC_LOAD, 0, 0, KIND_OPEN);
      push_item(FUNC_LOAD, 0, 1, KIND_OPEN);
      push_item(FUNC_LOAD, 0, 2, KIND_OPEN);
      push_step();                               // nothing seen yet
      push_item(FUNC_LOAD, 0, 1, KIND_START);
      push_step();                               // start but no end
      push_item(FUNC_LOAD, 0, 2, KIND_END);
      push_step();                               // forward left
      push_step();                               // dead end, back right
      push_step();                               // forward right onto the goal
      push_step();                               // at goal
      push_item(FUNC_LOAD, 0, 1, KIND_START);    // restart clears the stack
      push_item(FUNC_LOAD, 0, 2, KIND_WALL);
      push_step();                               // boxed in with empty stack
      push_step();
      push_item(FUNC_LOAD, 63, 63, KIND_WALL);   // outside the grid in use
      settle();

      ep = 0;
      while (items_issued < ITEM_TARGET) begin
         if (ep % 4 == 0) configure(ep / 4);
         else if ($urandom_range(0, 2) == 0) settle();
         sender_jitter   = ($urandom_range(0, 3) != 0);
         receiver_jitter = ($urandom_range(0, 3) != 0);
         if (ep == 2 || ep == 19) sender_jitter = 1'b0;
         load_maze(ep == 2 || ep == 19);
         ep++;
      end
      settle();

      $display("covered %0d mazes: %0d cell loads, %0d steps checked, %0d register writes",
               mazes_run, loads_taken, steps_checked, csr_writes);
      $display("step outcomes: forward %0d, backtrack %0d, goal %0d, no path %0d, not ready %0d",
               status_seen[STS_FORWARD], status_seen[STS_BACK], status_seen[STS_GOAL],
               status_seen[STS_NOPATH], status_seen[STS_NOTREADY]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout: %0d results still expected", expected_steps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
